[rtl/lr_pkg.sv]
// Shared types and constants for the line rasterizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lr_pkg;

  localparam int COORD_W          = 8;
  localparam int COLOR_W          = 16;
  localparam int PIX_W            = 6;
  localparam int ADDR_W           = 12;
  localparam int ERR_W            = 12;
  localparam int RESULT_LIMIT     = 64;
  localparam int CNT_W            = $clog2(RESULT_LIMIT);
  localparam int CANVAS_WIDTH_DEF  = 64;
  localparam int CANVAS_HEIGHT_DEF = 64;
  localparam int IN_DATA_W        = 4 * COORD_W + COLOR_W;
  localparam int OUT_DATA_W       = 2 * PIX_W + ADDR_W + COLOR_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [ERR_W-1:0]   dx;
    logic signed [ERR_W-1:0]   dy;
    logic signed [ERR_W-1:0]   err;
    logic                      sx_neg;
    logic                      sy_neg;
    logic [COLOR_W-1:0]        color;
  } lr_cmd_t;

endpackage

[rtl/line_rasterizer.sv]
// Line rasterizer top level: front end, command queue and line walker.
// Depends on lr_pkg, lr_front, lr_cmd_fifo and lr_walker.
//
// Input channel (in_*): one line command per item, signed start and end
// points plus an RGB565 color. Output channel (out_*): one pixel write per
// visible point, out_tlast set on the final visible pixel of the line.
// Points off the canvas are dropped; a line with no visible point yields
// no item.
// A queued command is loaded by the walker from the idle state, and its
// first point is walked in the walk state that follows. A visible point is
// held in the pending register until the next visible point is walked or
// the line ends, and is then registered onto out_tvalid. Throughput: one
// walked point per cycle in the walker loop while the output is not stalled,
// and at most RESULT_LIMIT pixels are written per line.
// The front end keeps accepting commands until the queue holds two.
// When the receiver stalls, the walker holds on the next visible point
// and the queue fills, dropping in_tready.
// Reset (rst_n, synchronous, active low) empties the queue and the walker.
`timescale 1ns / 1ps

module line_rasterizer #(
  parameter int CANVAS_WIDTH  = lr_pkg::CANVAS_WIDTH_DEF,
  parameter int CANVAS_HEIGHT = lr_pkg::CANVAS_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // start_x[7:0], start_y[15:8], end_x[23:16], end_y[31:24], color[47:32]
  input  logic [lr_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // pixel_x[5:0], pixel_y[11:6], pixel_address[23:12], pixel_color[39:24]
  output logic [lr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);

  logic            wr_en, fifo_full, fifo_empty, fifo_rd;
  lr_pkg::lr_cmd_t wr_cmd, rd_cmd;

  lr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .fifo_full (fifo_full),
    .wr_en     (wr_en),
    .wr_cmd    (wr_cmd)
  );

  lr_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_cmd (wr_cmd),
    .full   (fifo_full),
    .rd_en  (fifo_rd),
    .empty  (fifo_empty),
    .rd_cmd (rd_cmd)
  );

  lr_walker #(
    .CANVAS_WIDTH  (CANVAS_WIDTH),
    .CANVAS_HEIGHT (CANVAS_HEIGHT)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .fifo_cmd   (rd_cmd),
    .fifo_rd    (fifo_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/lr_front.sv]
// Command front end: unpacks a line command and sets up the Bresenham terms.
// Depends on lr_pkg; feeds lr_cmd_fifo.
`timescale 1ns / 1ps

module lr_front (
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [lr_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                         fifo_full,
  output logic                         wr_en,
  output lr_pkg::lr_cmd_t              wr_cmd
);

  logic signed [lr_pkg::COORD_W-1:0] x0, y0, x1, y1;
  logic signed [lr_pkg::ERR_W-1:0]   x0e, y0e, x1e, y1e;
  logic signed [lr_pkg::ERR_W-1:0]   adx, ady;

  assign x0 = in_tdata[7:0];
  assign y0 = in_tdata[15:8];
  assign x1 = in_tdata[23:16];
  assign y1 = in_tdata[31:24];

  assign x0e = lr_pkg::ERR_W'(x0);
  assign y0e = lr_pkg::ERR_W'(y0);
  assign x1e = lr_pkg::ERR_W'(x1);
  assign y1e = lr_pkg::ERR_W'(y1);

  assign adx = (x1 > x0) ? (x1e - x0e) : (x0e - x1e);
  assign ady = (y1 > y0) ? (y1e - y0e) : (y0e - y1e);

  assign in_tready = !fifo_full;
  assign wr_en     = in_tvalid && !fifo_full;

  always_comb begin
    wr_cmd.x0     = x0;
    wr_cmd.y0     = y0;
    wr_cmd.x1     = x1;
    wr_cmd.y1     = y1;
    wr_cmd.dx     = adx;
    wr_cmd.dy     = -ady;
    wr_cmd.err    = adx - ady;
    wr_cmd.sx_neg = !(x0 < x1);
    wr_cmd.sy_neg = !(y0 < y1);
    wr_cmd.color  = in_tdata[47:32];
  end

endmodule

[rtl/lr_cmd_fifo.sv]
// Two-entry command queue between the front end and the line walker.
// Depends on lr_pkg for the command type.
`timescale 1ns / 1ps

module lr_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  lr_pkg::lr_cmd_t wr_cmd,
  output logic            full,
  input  logic            rd_en,
  output logic            empty,
  output lr_pkg::lr_cmd_t rd_cmd
);

  lr_pkg::lr_cmd_t mem_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      count_r;

  assign full   = (count_r == 2'd2);
  assign empty  = (count_r == 2'd0);
  assign rd_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= !wr_ptr_r;
      if (rd_en) rd_ptr_r <= !rd_ptr_r;
      unique case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/lr_walker.sv]
// Line walker: one Bresenham step per cycle unless the output stalls, canvas clip,
// one-pixel lookahead so the last visible pixel can be marked. Depends on lr_pkg.
`timescale 1ns / 1ps

module lr_walker #(
  parameter int CANVAS_WIDTH  = lr_pkg::CANVAS_WIDTH_DEF,
  parameter int CANVAS_HEIGHT = lr_pkg::CANVAS_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fifo_empty,
  input  lr_pkg::lr_cmd_t               fifo_cmd,
  output logic                          fifo_rd,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);

  localparam int PROD_W = 17;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FLUSH} state_t;

  state_t                            state_r;
  lr_pkg::lr_cmd_t                   cmd_r;
  logic signed [lr_pkg::COORD_W-1:0] x_r, y_r;
  logic signed [lr_pkg::ERR_W-1:0]   err_r;
  logic [lr_pkg::CNT_W-1:0]          cnt_r;
  logic                              pend_valid_r;
  logic [lr_pkg::COORD_W-1:0]        pend_x_r, pend_y_r;
  logic                              out_valid_r;
  logic                              out_last_r;
  logic [lr_pkg::OUT_DATA_W-1:0]     out_data_r;

  logic                              can_push, visible, done, stall, push, push_last;
  logic                              step_x, step_y;
  logic signed [lr_pkg::ERR_W:0]     e2;
  logic signed [lr_pkg::ERR_W-1:0]   err_nxt;
  logic signed [9:0]                 xs, ys;
  logic [PROD_W-1:0]                 addr_full;

  assign can_push = !out_valid_r || out_tready;
  assign xs       = 10'(x_r);
  assign ys       = 10'(y_r);
  assign visible  = (xs >= 0) && (xs < $signed(10'(CANVAS_WIDTH))) &&
                    (ys >= 0) && (ys < $signed(10'(CANVAS_HEIGHT)));
  assign done     = (x_r == cmd_r.x1) && (y_r == cmd_r.y1);
  assign stall    = visible && pend_valid_r && !can_push;

  assign e2      = {err_r, 1'b0};
  assign step_x  = e2 >= (lr_pkg::ERR_W + 1)'(cmd_r.dy);
  assign step_y  = e2 <= (lr_pkg::ERR_W + 1)'(cmd_r.dx);
  assign err_nxt = err_r + (step_x ? cmd_r.dy : '0) + (step_y ? cmd_r.dx : '0);

  assign fifo_rd = (state_r == ST_IDLE) && !fifo_empty;

  always_comb begin
    push      = 1'b0;
    push_last = 1'b0;
    unique case (state_r)
      ST_WALK:  push = !stall && visible && pend_valid_r;
      ST_FLUSH: begin
        push      = pend_valid_r && can_push;
        push_last = 1'b1;
      end
      default:  push = 1'b0;
    endcase
  end

  assign addr_full = PROD_W'(pend_y_r) * PROD_W'(CANVAS_WIDTH) + PROD_W'(pend_x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
      out_data_r   <= '0;
      cnt_r        <= '0;
    end else begin
      if (push) begin
        out_valid_r <= 1'b1;
        out_last_r  <= push_last;
        out_data_r  <= {cmd_r.color, addr_full[lr_pkg::ADDR_W-1:0],
                        pend_y_r[lr_pkg::PIX_W-1:0], pend_x_r[lr_pkg::PIX_W-1:0]};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!fifo_empty) begin
            cmd_r        <= fifo_cmd;
            x_r          <= fifo_cmd.x0;
            y_r          <= fifo_cmd.y0;
            err_r        <= fifo_cmd.err;
            cnt_r        <= '0;
            pend_valid_r <= 1'b0;
            state_r      <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!stall) begin
            if (visible) begin
              pend_valid_r <= 1'b1;
              pend_x_r     <= x_r;
              pend_y_r     <= y_r;
              cnt_r        <= cnt_r + 1'b1;
            end
            if (done || (visible && (cnt_r == lr_pkg::CNT_W'(lr_pkg::RESULT_LIMIT - 1)))) begin
              state_r <= ST_FLUSH;
            end else begin
              if (step_x) x_r <= cmd_r.sx_neg ? x_r - 1'b1 : x_r + 1'b1;
              if (step_y) y_r <= cmd_r.sy_neg ? y_r - 1'b1 : y_r + 1'b1;
              err_r <= err_nxt;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_r || can_push) begin
            pend_valid_r <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("pending pixel left over in idle");

  a_pop_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_rd |=> (state_r == ST_WALK))
    else $error("command pop did not start a walk");

  a_out_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_valid_r))
    else $error("output raised without a pending pixel");

  a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_last_r) |-> ($past(state_r) == ST_FLUSH))
    else $error("last pixel marked outside flush");

endmodule

[verif/tb_top.sv]
// Self-checking bench for line_rasterizer: line commands in, pixel writes out.
// Holds its own Bresenham walk with canvas clipping and checks each write in order.
// Depends on lr_pkg and the line_rasterizer RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int CANVAS_W    = lr_pkg::CANVAS_WIDTH_DEF;
  localparam int CANVAS_H    = lr_pkg::CANVAS_HEIGHT_DEF;
  localparam int DRAIN_CYC   = 1000;
  localparam int RANDOM_LINES = 190;
  localparam int CALM_FIRST  = 3000;
  localparam int CALM_LAST   = 9000;

  typedef struct {
    logic signed [lr_pkg::COORD_W-1:0] x0;
    logic signed [lr_pkg::COORD_W-1:0] y0;
    logic signed [lr_pkg::COORD_W-1:0] x1;
    logic signed [lr_pkg::COORD_W-1:0] y1;
    logic [lr_pkg::COLOR_W-1:0]        color;
  } line_cmd_t;

  typedef struct {
    logic [lr_pkg::PIX_W-1:0]   x;
    logic [lr_pkg::PIX_W-1:0]   y;
    logic [lr_pkg::ADDR_W-1:0]  addr;
    logic [lr_pkg::COLOR_W-1:0] color;
    logic                       last;
  } pixel_write_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [lr_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [lr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                          out_tlast;

  line_cmd_t    pending_lines[$];
  pixel_write_t expected_pixels[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  logic         in_fire = 1'b0;

  line_rasterizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // breaks with a chance of about 28 in 100, none inside the calm window
  function automatic bit take_break();
    if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) return 1'b0;
    return $urandom_range(0, 99) < 28;
  endfunction

  function automatic void rasterize_line(line_cmd_t cmd);
    int x, y, xe, ye, dx, dy, sx, sy, err, e2, n;
    pixel_write_t held;
    bit have_held;
    x  = $signed(cmd.x0);
    y  = $signed(cmd.y0);
    xe = $signed(cmd.x1);
    ye = $signed(cmd.y1);
    dx = (xe > x) ? xe - x : x - xe;
    dy = -((ye > y) ? ye - y : y - ye);
    sx = (x < xe) ? 1 : -1;
    sy = (y < ye) ? 1 : -1;
    err = dx + dy;
    n = 0;
    have_held = 1'b0;
    forever begin
      if (x >= 0 && x < CANVAS_W && y >= 0 && y < CANVAS_H) begin
        if (have_held) expected_pixels.push_back(held);
        held.x     = x[lr_pkg::PIX_W-1:0];
        held.y     = y[lr_pkg::PIX_W-1:0];
        held.addr  = lr_pkg::ADDR_W'(y * CANVAS_W + x);
        held.color = cmd.color;
        held.last  = 1'b0;
        have_held  = 1'b1;
        n++;
        if (n >= lr_pkg::RESULT_LIMIT) break;
      end
      if (x == xe && y == ye) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        y += sy;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_pixels.push_back(held);
    end
  endfunction

  task automatic queue_line(int x0, int y0, int x1, int y1, int color);
    line_cmd_t cmd;
    cmd.x0    = x0[lr_pkg::COORD_W-1:0];
    cmd.y0    = y0[lr_pkg::COORD_W-1:0];
    cmd.x1    = x1[lr_pkg::COORD_W-1:0];
    cmd.y1    = y1[lr_pkg::COORD_W-1:0];
    cmd.color = color[lr_pkg::COLOR_W-1:0];
    pending_lines.push_back(cmd);
  endtask

  // driver: presents queued commands at the falling edge
  always @(negedge clk) begin
    line_cmd_t cmd;
    cycle_count <= cycle_count + 1;
    out_tready <= rst_n && !take_break();
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      in_tvalid <= 1'b1;
    end else if (pending_lines.size() != 0 && !take_break()) begin
      cmd = pending_lines.pop_front();
      in_tdata  <= {cmd.color, cmd.y1, cmd.x1, cmd.y0, cmd.x0};
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // monitor: predicts on accepted commands, checks accepted pixel writes
  always @(posedge clk) begin
    line_cmd_t cmd;
    pixel_write_t exp_px;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      cmd.x0    = in_tdata[7:0];
      cmd.y0    = in_tdata[15:8];
      cmd.x1    = in_tdata[23:16];
      cmd.y1    = in_tdata[31:24];
      cmd.color = in_tdata[47:32];
      rasterize_line(cmd);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: expected no pixel write, actual x=%0d y=%0d addr=%0d color=%h last=%b",
                 $time, out_tdata[5:0], out_tdata[11:6], out_tdata[23:12],
                 out_tdata[39:24], out_tlast);
        mismatch_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_tdata[5:0] !== exp_px.x) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time, exp_px.x, out_tdata[5:0]);
          mismatch_count++;
        end
        if (out_tdata[11:6] !== exp_px.y) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time, exp_px.y, out_tdata[11:6]);
          mismatch_count++;
        end
        if (out_tdata[23:12] !== exp_px.addr) begin
          $display("%0t: pixel_address expected %0d actual %0d",
                   $time, exp_px.addr, out_tdata[23:12]);
          mismatch_count++;
        end
        if (out_tdata[39:24] !== exp_px.color) begin
          $display("%0t: pixel_color expected %h actual %h",
                   $time, exp_px.color, out_tdata[39:24]);
          mismatch_count++;
        end
        if (out_tlast !== exp_px.last) begin
          $display("%0t: last_pixel expected %b actual %b", $time, exp_px.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int mode, ax, ay, bx, by;
    rst_n = 1'b0;

    // directed: points, diagonals, extremes, straight lines, all octants, clipping
    queue_line(10, 20, 10, 20, 16'h1234);
    queue_line(-5, 70, -5, 70, 16'hFFFF);
    queue_line(0, 0, 63, 63, 16'h0000);
    queue_line(63, 0, 0, 63, 16'hFFFF);
    queue_line(-128, -128, 127, 127, 16'hF800);
    queue_line(127, 127, -128, -128, 16'h07E0);
    queue_line(127, -128, -128, 127, 16'h001F);
    queue_line(-128, 5, 127, 5, 16'hAAAA);
    queue_line(40, -128, 40, 127, 16'h5555);
    queue_line(32, 32, 40, 35, 16'h0001);
    queue_line(32, 32, 35, 40, 16'h8000);
    queue_line(32, 32, 24, 35, 16'h0F0F);
    queue_line(32, 32, 29, 40, 16'hF0F0);
    queue_line(32, 32, 24, 29, 16'h00FF);
    queue_line(32, 32, 29, 24, 16'hFF00);
    queue_line(32, 32, 40, 29, 16'h3C3C);
    queue_line(32, 32, 35, 24, 16'hC3C3);
    queue_line(70, 70, 100, 127, 16'h1111);
    queue_line(-10, -10, -1, -1, 16'h2222);
    queue_line(-20, 10, 80, 30, 16'h7777);
    queue_line(0, 63, 63, 0, 16'hFFFF);
    queue_line(63, 63, 63, 63, 16'h0000);

    repeat (RANDOM_LINES) begin
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
        ax = $urandom_range(0, 95) - 16;
        ay = $urandom_range(0, 95) - 16;
        bx = $urandom_range(0, 95) - 16;
        by = $urandom_range(0, 95) - 16;
      end else if (mode < 80) begin
        ax = $urandom_range(0, 63);
        ay = $urandom_range(0, 63);
        bx = ax + $urandom_range(0, 8) - 4;
        by = ay + $urandom_range(0, 8) - 4;
      end else begin
        ax = $urandom_range(0, 255) - 128;
        ay = $urandom_range(0, 255) - 128;
        bx = $urandom_range(0, 255) - 128;
        by = $urandom_range(0, 255) - 128;
      end
      queue_line(ax, ay, bx, by, $urandom_range(0, 65535));
    end

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    @(posedge clk);
    while (pending_lines.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("** line_rasterizer: PASSED **");
    end else begin
      $display("** line_rasterizer: FAILED **");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("%0t: timeout, %0d pixel writes still expected", $time, expected_pixels.size());
    $display("** line_rasterizer: FAILED **");
    $finish;
  end

endmodule
